[rtl/core/evbc_pkg.sv]
// ----------------------------------------------------------------------------
// evbc_pkg
// Shared constants and types for the Ethernet/VLAN/IPv4 byte classifier.
// ----------------------------------------------------------------------------
package evbc_pkg;

    localparam logic [15:0] TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] TYPE_VLAN  = 16'h8100;
    localparam logic [15:0] TYPE_QINQ  = 16'h88A8;
    localparam logic [3:0]  IP_VERSION = 4'd4;
    localparam logic [3:0]  IP_MIN_IHL = 4'd5;

    // Frame offsets of the type fields and header starts
    localparam logic [5:0]  OFF_ETH_TYPE  = 6'd13;
    localparam logic [5:0]  OFF_TAG1_TYPE = 6'd17;
    localparam logic [5:0]  OFF_TAG2_TYPE = 6'd21;
    localparam logic [4:0]  START_UNTAGGED = 5'd14;
    localparam logic [4:0]  START_ONE_TAG  = 5'd18;
    localparam logic [4:0]  START_TWO_TAGS = 5'd22;

    // One result item
    typedef struct packed {
        logic        counted;
        logic [31:0] remote_address;
        logic [15:0] byte_length;
    } evbc_result_t;

    // Input item held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } evbc_item_t;

endpackage

[rtl/core/ethernet_vlan_ipv4_byte_classifier.sv]
// ----------------------------------------------------------------------------
// ethernet_vlan_ipv4_byte_classifier
// Per-frame IPv4 header classifier over a byte stream with VLAN/QinQ skip.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, data_byte, last_byte) carries one frame
//   byte per item in wire order; last_byte marks the frame's final byte.
//   Output channel (out_valid/out_ready) carries one result per frame, made
//   when the last byte is processed: counted, remote_address, byte_length.
//   cfg_write_en/cfg_write_data set use_destination (0 source, 1 dest).
//   Throughput: one byte per cycle unless a last byte is held, as below.
//   A byte is held in the input register, and its frame result is then
//   loaded into the result register, which drives out_valid.
//   Bytes that end no frame never wait on the output side; a last byte waits
//   in the input register while a previous result is still unclaimed, which
//   drops in_ready until out_ready frees the result register.
//   Reset clears parser state, both valid flags and use_destination.
// ----------------------------------------------------------------------------
module ethernet_vlan_ipv4_byte_classifier
    import evbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        counted,
    output logic [31:0] remote_address,
    output logic [15:0] byte_length
);

    evbc_item_t   in_item;
    evbc_item_t   item;
    logic         item_valid;
    logic         item_take;
    logic         can_load;
    evbc_result_t parse_result;
    evbc_result_t out_result;

    assign in_item.data_byte = data_byte;
    assign in_item.last_byte = last_byte;

    // a last byte needs room in the result register
    assign item_take = item_valid && (!item.last_byte || can_load);

    evbc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    evbc_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .step           (item_take),
        .item           (item),
        .result         (parse_result)
    );

    evbc_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (item_take && item.last_byte),
        .load_result (parse_result),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (out_result)
    );

    assign counted        = out_result.counted;
    assign remote_address = out_result.remote_address;
    assign byte_length    = out_result.byte_length;

endmodule

[rtl/core/evbc_in_stage.sv]
// ----------------------------------------------------------------------------
// evbc_in_stage
// Input register for the byte channel; holds one item until the parser takes it.
// ----------------------------------------------------------------------------
module evbc_in_stage
    import evbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  evbc_item_t in_item,
    output logic       item_valid,
    input  logic       item_take,
    output evbc_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    evbc_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/core/evbc_parser.sv]
// ----------------------------------------------------------------------------
// evbc_parser
// Per-frame header parser state and next-state logic, one byte per step.
// ----------------------------------------------------------------------------
module evbc_parser
    import evbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_en,
    input  logic         cfg_write_data,
    input  logic         step,
    input  evbc_item_t   item,
    output evbc_result_t result
);

    typedef enum logic [2:0] {
        PH_ETH  = 3'd0,
        PH_TAG1 = 3'd1,
        PH_TAG2 = 3'd2,
        PH_IPV4 = 3'd3,
        PH_DONE = 3'd4,
        PH_REJ  = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  offset_reg, offset_next;
    logic [15:0] type_reg, type_next;
    logic [4:0]  start_reg, start_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] addr_reg, addr_next;
    logic        use_dest_reg;

    logic [15:0] type_shifted;
    logic [5:0]  rel;
    logic        active;
    logic        is_tag;

    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        type_next    = type_reg;
        start_next   = start_reg;
        length_next  = length_reg;
        addr_next    = addr_reg;
        type_shifted = {type_reg[7:0], item.data_byte};
        rel          = offset_reg - {1'b0, start_reg};
        is_tag       = (type_shifted == TYPE_VLAN) || (type_shifted == TYPE_QINQ);
        active       = (phase_reg == PH_ETH) || (phase_reg == PH_TAG1) ||
                       (phase_reg == PH_TAG2) || (phase_reg == PH_IPV4);

        if (active)
        begin
            type_next = type_shifted;
            case (phase_reg)
                PH_ETH:
                begin
                    if (offset_reg == OFF_ETH_TYPE)
                    begin
                        if (is_tag)
                        begin
                            phase_next = PH_TAG1;
                            start_next = START_ONE_TAG;
                        end
                        else if (type_shifted == TYPE_IPV4)
                        begin
                            phase_next = PH_IPV4;
                            start_next = START_UNTAGGED;
                        end
                        else
                        begin
                            phase_next = PH_REJ;
                        end
                    end
                end
                PH_TAG1:
                begin
                    if (offset_reg == OFF_TAG1_TYPE)
                    begin
                        if (type_shifted == TYPE_VLAN)
                        begin
                            phase_next = PH_TAG2;
                            start_next = START_TWO_TAGS;
                        end
                        else if (type_shifted == TYPE_IPV4)
                        begin
                            phase_next = PH_IPV4;
                            start_next = START_ONE_TAG;
                        end
                        else
                        begin
                            phase_next = PH_REJ;
                        end
                    end
                end
                PH_TAG2:
                begin
                    if (offset_reg == OFF_TAG2_TYPE)
                    begin
                        if (type_shifted == TYPE_IPV4)
                        begin
                            phase_next = PH_IPV4;
                            start_next = START_TWO_TAGS;
                        end
                        else
                        begin
                            phase_next = PH_REJ;
                        end
                    end
                end
                default:
                begin
                    // IPv4 header byte at position rel
                    if (rel == 6'd0)
                    begin
                        if ((item.data_byte[7:4] != IP_VERSION) ||
                            (item.data_byte[3:0] < IP_MIN_IHL))
                        begin
                            phase_next = PH_REJ;
                        end
                    end
                    else if ((rel == 6'd2) || (rel == 6'd3))
                    begin
                        length_next = {length_reg[7:0], item.data_byte};
                    end
                    else if ((rel >= 6'd12) && (rel <= 6'd15))
                    begin
                        if (!use_dest_reg)
                        begin
                            addr_next = {addr_reg[23:0], item.data_byte};
                        end
                    end
                    else if ((rel >= 6'd16) && (rel <= 6'd19))
                    begin
                        if (use_dest_reg)
                        begin
                            addr_next = {addr_reg[23:0], item.data_byte};
                        end
                        if (rel == 6'd19)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
            endcase

            if ((phase_next != PH_DONE) && (phase_next != PH_REJ))
            begin
                offset_next = offset_reg + 6'd1;
            end
        end

        result.counted        = (phase_next == PH_DONE);
        result.remote_address = result.counted ? addr_next : 32'd0;
        result.byte_length    = result.counted ? length_next : 16'd0;

        // frame ends: re-arm for the next one
        if (item.last_byte)
        begin
            phase_next  = PH_ETH;
            offset_next = 6'd0;
            type_next   = 16'd0;
            start_next  = START_UNTAGGED;
            length_next = 16'd0;
            addr_next   = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ETH;
            offset_reg   <= 6'd0;
            type_reg     <= 16'd0;
            start_reg    <= START_UNTAGGED;
            length_reg   <= 16'd0;
            addr_reg     <= 32'd0;
            use_dest_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                use_dest_reg <= cfg_write_data;
            end
            if (step)
            begin
                phase_reg  <= phase_next;
                offset_reg <= offset_next;
                type_reg   <= type_next;
                start_reg  <= start_next;
                length_reg <= length_next;
                addr_reg   <= addr_next;
            end
        end
    end

endmodule

[rtl/core/evbc_out_stage.sv]
// ----------------------------------------------------------------------------
// evbc_out_stage
// Result register for the output channel.
// ----------------------------------------------------------------------------
module evbc_out_stage
    import evbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  evbc_result_t load_result,
    output logic         can_load,
    output logic         out_valid,
    input  logic         out_ready,
    output evbc_result_t result
);

    logic         valid_reg;
    logic         valid_next;
    evbc_result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule
